// File: src/matrix3_inverse_fixed_macros.svh
// Assertion helpers for the matrix inverse block.
`ifndef MATRIX3_INVERSE_FIXED_MACROS_SVH
`define MATRIX3_INVERSE_FIXED_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define M3INV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define M3INV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/m3inv_pkg.sv
package m3inv_pkg;
   localparam int ELEMENT_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF     = 16;
endpackage

// File: src/m3inv_req_if.sv
interface m3inv_req_if import m3inv_pkg::*; #(parameter int EW = ELEMENT_WIDTH_DEF) ();
   logic                 valid;
   logic                 ready;
   logic signed [EW-1:0] in_r0c0;
   logic signed [EW-1:0] in_r0c1;
   logic signed [EW-1:0] in_r0c2;
   logic signed [EW-1:0] in_r1c0;
   logic signed [EW-1:0] in_r1c1;
   logic signed [EW-1:0] in_r1c2;
   logic signed [EW-1:0] in_r2c0;
   logic signed [EW-1:0] in_r2c1;
   logic signed [EW-1:0] in_r2c2;

   modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
   modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

// File: src/m3inv_rsp_if.sv
interface m3inv_rsp_if import m3inv_pkg::*; #(parameter int EW = ELEMENT_WIDTH_DEF) ();
   logic                 valid;
   logic                 ready;
   logic signed [EW-1:0] out_r0c0;
   logic signed [EW-1:0] out_r0c1;
   logic signed [EW-1:0] out_r0c2;
   logic signed [EW-1:0] out_r1c0;
   logic signed [EW-1:0] out_r1c1;
   logic signed [EW-1:0] out_r1c2;
   logic signed [EW-1:0] out_r2c0;
   logic signed [EW-1:0] out_r2c1;
   logic signed [EW-1:0] out_r2c2;
   logic                 singular;
   logic                 saturated;

   modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                   input ready);
   modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                 out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                 output ready);
endinterface

// File: src/m3inv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module m3inv_div #(
   parameter int NW = 97,
   parameter int DW = 99,
   parameter int QB = 33
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quo,
   output logic          ovf
);
   localparam int XW = ((NW > DW + QB) ? NW : DW + QB) + 1;

   logic [XW-1:0] rem_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];

   // entry stage: flag quotients that cannot fit in QB bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= XW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= XW'(num) >= (XW'(den) << QB);
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      localparam int B = QB - k;
      logic [XW-1:0] shd;
      logic          take;

      always_comb begin
         shd  = XW'(den_ff[k-1]) << B;
         take = rem_ff[k-1] >= shd;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]    <= q_ff[k-1] | (QB'(take) << B);
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end

      if (k < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? rem_ff[k-1] - shd : rem_ff[k-1];
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quo = q_ff[QB];
   assign ovf = ovf_ff[QB];
endmodule

// File: src/matrix3_inverse_fixed.sv
// 3x3 matrix inverse by adjugate, signed fixed point, fully pipelined.
// Throughput: one matrix per cycle; the whole pipe stalls only while a
// result waits at the output and the sink is not ready.
// Reset (synchronous, active high) clears the valid bits; data is not reset.
`include "matrix3_inverse_fixed_macros.svh"

module matrix3_inverse_fixed import m3inv_pkg::*; #(
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   m3inv_req_if.sink  req,
   m3inv_rsp_if.source rsp
);
   localparam int EW   = ELEMENT_WIDTH;
   localparam int PW   = 2 * EW;          // 2x2 product
   localparam int CW   = 2 * EW + 1;      // cofactor
   localparam int DETW = 3 * EW + 3;      // determinant, exact
   localparam int NW   = CW + 2 * FRAC_BITS; // |adj| << 2F
   localparam int QB   = EW + 1;          // quotient bits kept
   localparam int NPRE = 6;               // stages ahead of the divider
   localparam int DEPTH = NPRE + QB + 1;

   // ---------------- stall control ----------------
   // Every stage moves together; only a blocked output holds the pipe.
   logic             en;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             rsp_vld_ff;

   assign en        = !rsp_vld_ff || rsp.ready;
   // no item is taken while reset clears the valid bits
   assign req.ready = en && !reset;

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   // ---------------- stage 1: capture matrix ----------------
   logic signed [EW-1:0] m_in [3][3];
   logic signed [EW-1:0] m_ff [3][3];

   always_comb begin
      m_in[0][0] = req.in_r0c0; m_in[0][1] = req.in_r0c1; m_in[0][2] = req.in_r0c2;
      m_in[1][0] = req.in_r1c0; m_in[1][1] = req.in_r1c1; m_in[1][2] = req.in_r1c2;
      m_in[2][0] = req.in_r2c0; m_in[2][1] = req.in_r2c1; m_in[2][2] = req.in_r2c2;
   end

   always_ff @(posedge clock) begin
      if (en) m_ff <= m_in;
   end

   // ---------------- stages 2-3: 2x2 cofactors ----------------
   // Cyclic row/column choice folds the cofactor sign into the ordering.
   logic signed [PW-1:0] pa_ff [3][3];
   logic signed [PW-1:0] pb_ff [3][3];
   logic signed [EW-1:0] row0_ff [3];
   logic signed [EW-1:0] row0b_ff [3];
   logic signed [CW-1:0] cof_ff [3][3];

   for (genvar r = 0; r < 3; r++) begin : g_cr
      for (genvar c = 0; c < 3; c++) begin : g_cc
         localparam int R1 = (r + 1) % 3;
         localparam int R2 = (r + 2) % 3;
         localparam int C1 = (c + 1) % 3;
         localparam int C2 = (c + 2) % 3;
         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[r][c]  <= m_ff[R1][C1] * m_ff[R2][C2];
               pb_ff[r][c]  <= m_ff[R1][C2] * m_ff[R2][C1];
               cof_ff[r][c] <= CW'(pa_ff[r][c]) - CW'(pb_ff[r][c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row0_ff  <= m_ff[0];
         row0b_ff <= row0_ff;
      end
   end

   // ---------------- stages 4-5: determinant ----------------
   // Each row-0 term is cut into two partial products of about EW x EW.
   logic signed [2*EW+1:0] plo_ff [3];
   logic signed [PW-1:0]   phi_ff [3];
   logic signed [CW-1:0]   cof4_ff [3][3];
   logic signed [CW-1:0]   cof5_ff [3][3];
   logic signed [DETW-1:0] det_in, det_ff;

   for (genvar c = 0; c < 3; c++) begin : g_dp
      always_ff @(posedge clock) begin
         if (en) begin
            plo_ff[c] <= row0b_ff[c] * $signed({1'b0, cof_ff[0][c][EW:0]});
            phi_ff[c] <= row0b_ff[c] * $signed(cof_ff[0][c][CW-1:EW+1]);
         end
      end
   end

   always_comb begin
      det_in = '0;
      for (int c = 0; c < 3; c++) begin
         det_in = det_in + (DETW'(phi_ff[c]) <<< (EW + 1)) + DETW'(plo_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cof4_ff <= cof_ff;
         cof5_ff <= cof4_ff;
         det_ff  <= det_in;
      end
   end

   // ---------------- stage 6: magnitudes and signs ----------------
   logic [DETW-1:0] den_ff;
   logic [CW-1:0]   amag_ff [3][3];
   logic [8:0]      neg_in, neg_ff;
   logic            sing_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            // adjugate is the transposed cofactor matrix
            neg_in[r*3+c] = cof5_ff[c][r][CW-1] ^ det_ff[DETW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= det_ff[DETW-1] ? DETW'(-det_ff) : DETW'(det_ff);
         sing_ff <= det_ff == '0;
         neg_ff  <= neg_in;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               amag_ff[r][c] <= cof5_ff[c][r][CW-1] ? CW'(-cof5_ff[c][r])
                                                    : CW'(cof5_ff[c][r]);
            end
         end
      end
   end

   // ---------------- divider stages ----------------
   logic [QB-1:0] quo_w [9];
   logic [8:0]    ovf_w;
   logic [8:0]    negd_ff [QB+1];
   logic          singd_ff [QB+1];

   for (genvar i = 0; i < 9; i++) begin : g_div
      m3inv_div #(.NW(NW), .DW(DETW), .QB(QB)) u_div (
         .clock (clock),
         .en    (en),
         .num   ({amag_ff[i/3][i%3], {(2*FRAC_BITS){1'b0}}}),
         .den   (den_ff),
         .quo   (quo_w[i]),
         .ovf   (ovf_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         negd_ff[0]  <= neg_ff;
         singd_ff[0] <= sing_ff;
         for (int k = 1; k <= QB; k++) begin
            negd_ff[k]  <= negd_ff[k-1];
            singd_ff[k] <= singd_ff[k-1];
         end
      end
   end

   // ---------------- output stage: sign, saturate ----------------
   localparam logic [QB-1:0] POS_LIM = (QB'(1) << (EW - 1)) - QB'(1);
   localparam logic [QB-1:0] NEG_LIM = QB'(1) << (EW - 1);

   logic signed [EW-1:0] res_in [9];
   logic signed [EW-1:0] res_ff [9];
   logic [8:0]           clip;
   logic                 sat_ff, sing_out_ff;
   logic [QB-1:0]        mag;

   always_comb begin
      mag = '0;
      for (int i = 0; i < 9; i++) begin
         if (negd_ff[QB][i]) begin
            clip[i] = ovf_w[i] || (quo_w[i] > NEG_LIM);
            mag     = clip[i] ? NEG_LIM : quo_w[i];
            res_in[i] = EW'(-mag);
         end else begin
            clip[i] = ovf_w[i] || (quo_w[i] > POS_LIM);
            mag     = clip[i] ? POS_LIM : quo_w[i];
            res_in[i] = EW'(mag);
         end
         if (singd_ff[QB]) begin
            clip[i]   = 1'b0;
            res_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff      <= res_in;
         sat_ff      <= |clip;
         sing_out_ff <= singd_ff[QB];
      end
   end

   assign rsp.valid     = rsp_vld_ff;
   assign rsp.out_r0c0  = res_ff[0];
   assign rsp.out_r0c1  = res_ff[1];
   assign rsp.out_r0c2  = res_ff[2];
   assign rsp.out_r1c0  = res_ff[3];
   assign rsp.out_r1c1  = res_ff[4];
   assign rsp.out_r1c2  = res_ff[5];
   assign rsp.out_r2c0  = res_ff[6];
   assign rsp.out_r2c1  = res_ff[7];
   assign rsp.out_r2c2  = res_ff[8];
   assign rsp.singular  = sing_out_ff;
   assign rsp.saturated = sat_ff;

   // ---------------- checks ----------------
   `M3INV_ASSERT_NOW(a_sing_clean, rsp.valid && rsp.singular,
      !rsp.saturated && rsp.out_r0c0 == '0 && rsp.out_r1c1 == '0 && rsp.out_r2c2 == '0,
      "singular result with nonzero data")
   `M3INV_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, vld_ff[0],
      "accepted item missing from pipe")
   `M3INV_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_ff) && rsp.valid,
      "pipe moved during stall")
endmodule

// File: test/m3inv_tb_if.sv
`timescale 1ns / 1ps

// Interfaces for the testbench side are the RTL's own (m3inv_req_if, m3inv_rsp_if).
// This file holds the shared item types used by the testbench.
package m3inv_tb_pkg;
   import m3inv_pkg::*;
   localparam int EW = ELEMENT_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;

   typedef logic signed [EW-1:0] elem_type;

   typedef struct {
      elem_type m [9];
   } matrix_type;

   typedef struct {
      elem_type m [9];
      logic     singular;
      logic     saturated;
   } inverse_type;
endpackage

// File: test/matrix3_inverse_fixed_tb.sv
`timescale 1ns / 1ps

module matrix3_inverse_fixed_tb;
   import m3inv_pkg::*;
   import m3inv_tb_pkg::*;

   // Wide signed arithmetic for exact cofactors and determinant.
   typedef logic signed [255:0] wide_type;

   localparam int LATENCY = EW + 9;

   logic clock = 1'b0;
   logic reset = 1'b1;

   m3inv_req_if #(.EW(EW)) req ();
   m3inv_rsp_if #(.EW(EW)) rsp ();

   matrix3_inverse_fixed u_top (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always #5 clock = ~clock;

   matrix_type  matrix_queue [$];   // matrices waiting to be offered
   inverse_type inverse_queue [$];  // expected inverses, oldest first
   int          error_count = 0;
   int          send_idle_pct = 35;
   int          recv_idle_pct = 64;
   int          hold_cycles = 0;    // long receiver hold-off, counted below
   bit          stim_done = 1'b0;
   bit          in_fire = 1'b0;     // item taken at the last rising edge

   // Predict the inverse: exact adjugate over determinant, truncated, saturated; all zero if singular.
   function automatic inverse_type invert_matrix(matrix_type a);
      inverse_type res;
      wide_type    e [3][3];
      wide_type    cof [3][3];
      wide_type    det, adj, num, den, quo;
      wide_type    pos_lim, neg_lim;
      bit          neg;
      pos_lim = (wide_type'(1) <<< (EW - 1)) - 1;
      neg_lim = wide_type'(1) <<< (EW - 1);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            e[r][c] = wide_type'(a.m[r*3+c]);
      // cyclic indices give the cofactor sign for free
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            cof[r][c] = e[(r+1)%3][(c+1)%3] * e[(r+2)%3][(c+2)%3]
                      - e[(r+1)%3][(c+2)%3] * e[(r+2)%3][(c+1)%3];
      det = e[0][0]*cof[0][0] + e[0][1]*cof[0][1] + e[0][2]*cof[0][2];
      res.saturated = 1'b0;
      res.singular  = (det == 0);
      for (int i = 0; i < 9; i++) res.m[i] = '0;
      if (det == 0) return res;
      den = (det < 0) ? -det : det;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            adj = cof[c][r];
            neg = (adj < 0) != (det < 0);
            num = ((adj < 0) ? -adj : adj) <<< (2 * FB);
            quo = num / den;
            if (neg) begin
               if (quo > neg_lim) begin
                  quo = neg_lim;
                  res.saturated = 1'b1;
               end
               res.m[r*3+c] = elem_type'(-quo);
            end else begin
               if (quo > pos_lim) begin
                  quo = pos_lim;
                  res.saturated = 1'b1;
               end
               res.m[r*3+c] = elem_type'(quo);
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [EW-1:0] got, logic [EW-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic elem_type rand_elem();
      case ($urandom_range(0, 5))
         0: return elem_type'($urandom_range(0, 3) << FB);       // small integers
         1: return -elem_type'($urandom_range(0, 3) << FB);
         2: return elem_type'($signed($urandom)) >>> $urandom_range(8, 20);
         3: return $urandom_range(0, 1) ? {1'b0, {(EW-1){1'b1}}} : {1'b1, {(EW-1){1'b0}}};
         default: return elem_type'($urandom);
      endcase
   endfunction

   // Input accept seen at the rising edge, for the driver at the next falling edge.
   always @(posedge clock) begin
      in_fire <= !reset && req.valid && req.ready;
   end

   // Driver: items change on the falling edge; valid held until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || in_fire) begin
         if (matrix_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            matrix_type nxt;
            nxt = matrix_queue.pop_front();
            req.valid   <= 1'b1;
            req.in_r0c0 <= nxt.m[0];
            req.in_r0c1 <= nxt.m[1];
            req.in_r0c2 <= nxt.m[2];
            req.in_r1c0 <= nxt.m[3];
            req.in_r1c1 <= nxt.m[4];
            req.in_r1c2 <= nxt.m[5];
            req.in_r2c0 <= nxt.m[6];
            req.in_r2c1 <= nxt.m[7];
            req.in_r2c2 <= nxt.m[8];
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with an occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready   <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on input accept, check on output accept.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            matrix_type got_in;
            got_in.m = '{req.in_r0c0, req.in_r0c1, req.in_r0c2, req.in_r1c0, req.in_r1c1,
                         req.in_r1c2, req.in_r2c0, req.in_r2c1, req.in_r2c2};
            inverse_queue = {inverse_queue, invert_matrix(got_in)};
         end
         if (rsp.valid && rsp.ready) begin
            inverse_type want;
            elem_type    got [9];
            got = '{rsp.out_r0c0, rsp.out_r0c1, rsp.out_r0c2, rsp.out_r1c0, rsp.out_r1c1,
                    rsp.out_r1c2, rsp.out_r2c0, rsp.out_r2c1, rsp.out_r2c2};
            if (inverse_queue.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = inverse_queue.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.m[i])
                     report_mismatch($sformatf("out_r%0dc%0d", i/3, i%3), got[i], want.m[i]);
               if (rsp.singular !== want.singular)
                  report_mismatch("singular", rsp.singular, want.singular);
               if (rsp.saturated !== want.saturated)
                  report_mismatch("saturated", rsp.saturated, want.saturated);
            end
         end
      end
   end

   task automatic push_matrix(elem_type a0, elem_type a1, elem_type a2, elem_type a3,
                              elem_type a4, elem_type a5, elem_type a6, elem_type a7,
                              elem_type a8);
      matrix_type mx;
      mx.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
      matrix_queue = {matrix_queue, mx};
   endtask

   task automatic wait_drained();
      while (matrix_queue.size() != 0 || req.valid || inverse_queue.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      elem_type   one, mx, mn, tiny;
      matrix_type r;
      one  = elem_type'(1) <<< FB;
      mx   = {1'b0, {(EW-1){1'b1}}};
      mn   = {1'b1, {(EW-1){1'b0}}};
      tiny = elem_type'(1);
      req.valid = 1'b0;
      req.in_r0c0 = '0; req.in_r0c1 = '0; req.in_r0c2 = '0;
      req.in_r1c0 = '0; req.in_r1c1 = '0; req.in_r1c2 = '0;
      req.in_r2c0 = '0; req.in_r2c1 = '0; req.in_r2c2 = '0;
      rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, scaled, singular, saturation both ways, extremes
      push_matrix(one, 0, 0, 0, one, 0, 0, 0, one);
      push_matrix(2*one, 0, 0, 0, -4*one, 0, 0, 0, one/2);
      push_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_matrix(one, 2*one, 3*one, 2*one, 4*one, 6*one, one, 0, one);
      push_matrix(tiny, 0, 0, 0, tiny, 0, 0, 0, tiny);          // huge positive inverse
      push_matrix(-tiny, 0, 0, 0, tiny, 0, 0, 0, tiny);         // huge negative inverse
      push_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx);
      push_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn);
      push_matrix(mn, mx, mn, mx, mn, mx, mn, mx, mx);
      push_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx);
      push_matrix(mn, mx, 0, mx, mn, 0, 0, 0, -one);
      push_matrix(-1, -1, 0, 0, -1, -1, -1, 0, -1);
      push_matrix(0, one, 0, 0, 0, one, one, 0, 0);             // permutation
      push_matrix(one, one, 0, one, one, 0, 0, 0, one);
      // exact -2^(EW-1) without saturation: diag with inverse = -32768.0
      push_matrix(-(one >>> 15), 0, 0, 0, one, 0, 0, 0, one);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 64 : 0;
         recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 35 : 0;
         for (int n = 0; n < 330; n++) begin
            for (int i = 0; i < 9; i++) r.m[i] = rand_elem();
            // some rank-deficient ones: row 2 copies row 0
            if ($urandom_range(0, 9) == 0) begin
               r.m[6] = r.m[0]; r.m[7] = r.m[1]; r.m[8] = r.m[2];
            end
            matrix_queue = {matrix_queue, r};
         end
         if (phase == 1) begin
            // fill the pipe while the receiver holds off
            while (matrix_queue.size() > 250) @(posedge clock);
            hold_cycles = 8 * LATENCY;
         end
         wait_drained();
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0)
         $display("matrix3_inverse_fixed regression: pass");
      else
         $display("matrix3_inverse_fixed regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("matrix3_inverse_fixed regression: fail");
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/m3inv_pkg.sv
src/m3inv_req_if.sv
src/m3inv_rsp_if.sv
src/m3inv_div.sv
src/matrix3_inverse_fixed.sv
test/m3inv_tb_if.sv
test/matrix3_inverse_fixed_tb.sv
